// File: design/slot_marker_ring_queue_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot marker ring queue core
// Clocked implication checks with reset gating, for use inside the top level.
// ----------------------------------------------------------------------------
`ifndef SLOT_MARKER_RING_QUEUE_CORE_ASSERT_SVH
`define SLOT_MARKER_RING_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds too.
`define SMRQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent holds in the following cycle.
`define SMRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/smrq_pkg.sv
// ----------------------------------------------------------------------------
// smrq_pkg
// Shared types and constants of the slot marker ring queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smrq_pkg;

    // Widths of the external fields.
    localparam int IO_WORD_W    = 32;
    localparam int IO_WORDS     = 4;
    localparam int BATCH_SIZE_W = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 4;

    // Operation codes carried in the kind field.
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_BATCH_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BATCH_SIZE   = 2'd1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_hold;
    } status_t;

endpackage

// File: design/smrq_ctrl.sv
// ----------------------------------------------------------------------------
// smrq_ctrl
// Controller: sequences the clearing pass, beat acceptance and commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smrq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  smrq_pkg::status_t status,
    output smrq_pkg::cmd_t    cmd
);
    import smrq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!status.out_hold)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.clr_wr = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                cmd.commit = !status.out_hold;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: design/smrq_dp.sv
// ----------------------------------------------------------------------------
// smrq_dp
// Datapath: slot memory, pointers, reserve mark, configuration and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smrq_dp #(
    parameter int CAPACITY  = 16,
    parameter int MSG_WORDS = 4,
    parameter int WORD_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  smrq_pkg::cmd_t                       cmd,
    output smrq_pkg::status_t                    status,
    input  logic                                 cfg_write,
    input  logic [smrq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [smrq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 kind,
    input  logic [smrq_pkg::IO_WORD_W-1:0]       first_word,
    input  logic [smrq_pkg::IO_WORD_W-1:0]       second_word,
    input  logic [smrq_pkg::IO_WORD_W-1:0]       third_word,
    input  logic [smrq_pkg::IO_WORD_W-1:0]       fourth_word,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic                                 accepted,
    output logic [smrq_pkg::IO_WORD_W-1:0]       out_first,
    output logic [smrq_pkg::IO_WORD_W-1:0]       out_second,
    output logic [smrq_pkg::IO_WORD_W-1:0]       out_third,
    output logic [smrq_pkg::IO_WORD_W-1:0]       out_fourth
);
    import smrq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int PTR_W = IDX_W + 1;
    localparam int ROW_W = MSG_WORDS * WORD_BITS;
    localparam int SUM_W = ((PTR_W > BATCH_SIZE_W) ? PTR_W : BATCH_SIZE_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CAPACITY - 1);
    localparam logic [ROW_W-1:0] MARK_MASK = ROW_W'({WORD_BITS{1'b1}});

    // Slot memory: one row per slot, word 0 in the low bits.
    logic [ROW_W-1:0] slot_mem [CAPACITY];

    logic [PTR_W-1:0]        rptr_reg;
    logic [PTR_W-1:0]        wptr_reg;
    logic [PTR_W-1:0]        rmark_reg;
    logic                    batch_en_reg;
    logic [BATCH_SIZE_W-1:0] batch_size_reg;
    logic [IDX_W-1:0]        clr_idx_reg;
    logic                    kind_reg;
    logic [ROW_W-1:0]        msg_reg;
    logic [ROW_W-1:0]        msg_next;
    logic [ROW_W-1:0]        rd_row_reg;
    logic                    out_valid_reg;
    logic                    accepted_reg;
    logic [IO_WORDS-1:0][IO_WORD_W-1:0] out_word_reg;
    logic [IO_WORDS-1:0][IO_WORD_W-1:0] out_word_next;
    logic [IO_WORDS-1:0][IO_WORD_W-1:0] in_words;

    logic [PTR_W-1:0] probe_ptr;
    logic             at_mark;
    logic [IDX_W-1:0] rd_idx;
    logic             occupied;
    logic             is_deq;
    logic             enq_check;
    logic             op_ok;
    logic             mem_we;
    logic [IDX_W-1:0] wr_idx;
    logic [ROW_W-1:0] wr_row;

    assign in_words = {fourth_word, third_word, second_word, first_word};

    // Probe position of the batch check and whether the producer sits on the mark.
    assign probe_ptr = PTR_W'(SUM_W'(rmark_reg) + SUM_W'(batch_size_reg));
    assign at_mark   = (wptr_reg == rmark_reg);

    // Read address chosen from the incoming beat.
    always_comb
    begin
        if (kind == KIND_DEQ)
        begin
            rd_idx = rptr_reg[IDX_W-1:0];
        end
        else if (batch_en_reg && at_mark)
        begin
            rd_idx = probe_ptr[IDX_W-1:0];
        end
        else
        begin
            rd_idx = wptr_reg[IDX_W-1:0];
        end
    end

    // Message row built from the incoming words.
    always_comb
    begin
        msg_next = '0;
        for (int k = 0; k < MSG_WORDS; k++)
        begin
            msg_next[k*WORD_BITS +: WORD_BITS] = WORD_BITS'(in_words[k]);
        end
    end

    // Decision on the row read for the held beat.
    assign occupied  = |rd_row_reg[WORD_BITS-1:0];
    assign is_deq    = (kind_reg == KIND_DEQ);
    assign enq_check = batch_en_reg ? at_mark : 1'b1;
    assign op_ok     = is_deq ? occupied : !(enq_check && occupied);

    // Single write port: clearing pass, enqueue store or marker clear on dequeue.
    always_comb
    begin
        mem_we = 1'b0;
        wr_idx = clr_idx_reg;
        wr_row = '0;
        if (cmd.clr_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.commit && op_ok)
        begin
            mem_we = 1'b1;
            if (is_deq)
            begin
                wr_idx = rptr_reg[IDX_W-1:0];
                wr_row = rd_row_reg & ~MARK_MASK;
            end
            else
            begin
                wr_idx = wptr_reg[IDX_W-1:0];
                wr_row = msg_reg;
            end
        end
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_idx] <= wr_row;
        end
        if (cmd.load)
        begin
            rd_row_reg <= slot_mem[rd_idx];
        end
    end

    // Beat capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            msg_reg  <= msg_next;
        end
    end

    // Result words: dequeued message or zeros.
    always_comb
    begin
        out_word_next = '0;
        if (is_deq && op_ok)
        begin
            for (int k = 0; k < MSG_WORDS; k++)
            begin
                out_word_next[k] = IO_WORD_W'(rd_row_reg[k*WORD_BITS +: WORD_BITS]);
            end
        end
    end

    // Pointers, reserve mark, clearing counter and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg       <= '0;
            wptr_reg       <= '0;
            rmark_reg      <= '0;
            batch_en_reg   <= 1'b0;
            batch_size_reg <= '0;
            clr_idx_reg    <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.commit && op_ok)
            begin
                if (is_deq)
                begin
                    rptr_reg <= rptr_reg + 1'b1;
                end
                else
                begin
                    wptr_reg <= wptr_reg + 1'b1;
                    if (batch_en_reg && at_mark)
                    begin
                        rmark_reg <= probe_ptr + 1'b1;
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BATCH_ENABLE: batch_en_reg   <= cfg_data[0];
                    REG_BATCH_SIZE:   batch_size_reg <= cfg_data[BATCH_SIZE_W-1:0];
                    default:          batch_en_reg   <= batch_en_reg;
                endcase
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            accepted_reg <= op_ok;
            out_word_reg <= out_word_next;
        end
    end

    assign status.clr_last = (clr_idx_reg == LAST_IDX);
    assign status.out_hold = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign out_first  = out_word_reg[0];
    assign out_second = out_word_reg[1];
    assign out_third  = out_word_reg[2];
    assign out_fourth = out_word_reg[3];

endmodule

// File: design/slot_marker_ring_queue_core.sv
// ----------------------------------------------------------------------------
// slot_marker_ring_queue_core
// Single-producer, single-consumer ring queue with empty markers in the slots.
// ----------------------------------------------------------------------------
// After reset the queue runs a clearing pass over the slot memory and
// accepts no beat during that time; configuration writes are taken throughout.
// Each operation then has an accept step, which reads the addressed slot
// from the single slot memory into a register, and a decision step, which
// decides the outcome, writes the slot back and loads the result register.
// A new beat is accepted only after the previous operation has committed; a
// result that waits in the output register stalls the next operation only
// at its decision step. A slot counts as empty when its first word is zero,
// so a message with a zero first word is stored but reads as empty.
`timescale 1ns / 1ps

module slot_marker_ring_queue_core #(
    parameter int CAPACITY  = 16,
    parameter int MSG_WORDS = 4,
    parameter int WORD_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [smrq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [smrq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [smrq_pkg::IO_WORD_W-1:0]   first_word,
    input  logic [smrq_pkg::IO_WORD_W-1:0]   second_word,
    input  logic [smrq_pkg::IO_WORD_W-1:0]   third_word,
    input  logic [smrq_pkg::IO_WORD_W-1:0]   fourth_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             accepted,
    output logic [smrq_pkg::IO_WORD_W-1:0]   out_first,
    output logic [smrq_pkg::IO_WORD_W-1:0]   out_second,
    output logic [smrq_pkg::IO_WORD_W-1:0]   out_third,
    output logic [smrq_pkg::IO_WORD_W-1:0]   out_fourth
);
    import smrq_pkg::*;

`include "slot_marker_ring_queue_core_assert.svh"

    cmd_t    cmd;
    status_t status;

    // Controller.
    smrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    smrq_dp #(
        .CAPACITY  (CAPACITY),
        .MSG_WORDS (MSG_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .first_word  (first_word),
        .second_word (second_word),
        .third_word  (third_word),
        .fourth_word (fourth_word),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .accepted    (accepted),
        .out_first   (out_first),
        .out_second  (out_second),
        .out_third   (out_third),
        .out_fourth  (out_fourth)
    );

    // Only one operation is in flight, so an accepted beat closes the input.
    `SMRQ_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
        "input accepted while an operation was in flight")

    // The clearing pass never overlaps beat acceptance.
    `SMRQ_ASSERT_SAME(a_clear_blocks_input, cmd.clr_wr, !in_ready && !cmd.commit,
        "beat activity during the clearing pass")

    // A commit never overwrites a result that is still waiting.
    `SMRQ_ASSERT_SAME(a_no_result_overwrite, cmd.commit, !(out_valid && !out_ready),
        "result register overwritten while held")

    // A result appears only after a commit.
    `SMRQ_ASSERT_SAME(a_result_from_commit, $rose(out_valid), $past(cmd.commit),
        "result valid without a commit")

endmodule

// File: verif/slot_marker_ring_queue_core_test.sv
// ----------------------------------------------------------------------------
// slot_marker_ring_queue_core_test
// Self-checking testbench for the slot marker ring queue core. A driver sends
// enqueue and dequeue beats from a queue of pending operations. An internal
// queue model predicts each reply, and a monitor compares every reply beat
// field by field. The run steps through several batch settings, with random
// idle bursts on both sides and one long hold on the reply channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_marker_ring_queue_core_test;

    import smrq_pkg::*;

    localparam int SLOTS        = 16;
    localparam int PTR_W        = $clog2(SLOTS) + 1;
    localparam int LONG_HOLD    = 150;
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT_CYCLES = 400000;

    // Register indexes past the defined ones; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic                 kind;
        logic [IO_WORD_W-1:0] w0;
        logic [IO_WORD_W-1:0] w1;
        logic [IO_WORD_W-1:0] w2;
        logic [IO_WORD_W-1:0] w3;
    } queue_op_t;

    typedef struct packed {
        logic                 ok;
        logic [IO_WORD_W-1:0] d0;
        logic [IO_WORD_W-1:0] d1;
        logic [IO_WORD_W-1:0] d2;
        logic [IO_WORD_W-1:0] d3;
    } queue_reply_t;

    // Clock, reset and block ports.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   kind = KIND_ENQ;
    logic [IO_WORD_W-1:0]   first_word = '0;
    logic [IO_WORD_W-1:0]   second_word = '0;
    logic [IO_WORD_W-1:0]   third_word = '0;
    logic [IO_WORD_W-1:0]   fourth_word = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   accepted;
    logic [IO_WORD_W-1:0]   out_first;
    logic [IO_WORD_W-1:0]   out_second;
    logic [IO_WORD_W-1:0]   out_third;
    logic [IO_WORD_W-1:0]   out_fourth;

    // Model state of the queue and its registers.
    logic [IO_WORD_W-1:0]    mdl_slots [SLOTS][IO_WORDS];
    logic [PTR_W-1:0]        mdl_rd_ptr;
    logic [PTR_W-1:0]        mdl_wr_ptr;
    logic [PTR_W-1:0]        mdl_mark;
    logic                    mdl_batch_en;
    logic [BATCH_SIZE_W-1:0] mdl_batch_size;

    // Operations still to send and replies still to arrive.
    queue_op_t    ops_to_send [$];
    queue_reply_t predicted_replies [$];

    // Flow control of both channels.
    int   send_gap = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   hold_requests = 0;
    int   holds_done = 0;
    logic quiet_tail = 1'b0;

    // Bookkeeping.
    int mismatch_count = 0;
    int cycle_count = 0;
    int settings_used = 0;
    int enq_stored = 0;
    int enq_full = 0;
    int deq_taken = 0;
    int deq_empty = 0;

    slot_marker_ring_queue_core #(
        .CAPACITY  (SLOTS),
        .MSG_WORDS (IO_WORDS),
        .WORD_BITS (IO_WORD_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .first_word  (first_word),
        .second_word (second_word),
        .third_word  (third_word),
        .fourth_word (fourth_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .out_first   (out_first),
        .out_second  (out_second),
        .out_third   (out_third),
        .out_fourth  (out_fourth)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Applies one operation to the model queue and returns the reply it gives.
    function automatic queue_reply_t apply_queue_op(queue_op_t op);
        queue_reply_t     reply;
        logic [PTR_W-1:0] probe;
        logic             refused;
        reply   = '0;
        refused = 1'b0;
        if (op.kind == KIND_ENQ)
        begin
            // In batch mode the slot check only runs when the writer reaches the mark.
            if (mdl_batch_en)
            begin
                if (mdl_wr_ptr == mdl_mark)
                begin
                    probe = mdl_mark + PTR_W'(mdl_batch_size);
                    if (mdl_slots[probe[PTR_W-2:0]][0] != '0)
                        refused = 1'b1;
                    else
                        mdl_mark = probe + 1'b1;
                end
            end
            else if (mdl_slots[mdl_wr_ptr[PTR_W-2:0]][0] != '0)
            begin
                refused = 1'b1;
            end
            if (refused)
            begin
                enq_full++;
            end
            else
            begin
                mdl_slots[mdl_wr_ptr[PTR_W-2:0]][0] = op.w0;
                mdl_slots[mdl_wr_ptr[PTR_W-2:0]][1] = op.w1;
                mdl_slots[mdl_wr_ptr[PTR_W-2:0]][2] = op.w2;
                mdl_slots[mdl_wr_ptr[PTR_W-2:0]][3] = op.w3;
                mdl_wr_ptr = mdl_wr_ptr + 1'b1;
                reply.ok   = 1'b1;
                enq_stored++;
            end
        end
        else if (mdl_slots[mdl_rd_ptr[PTR_W-2:0]][0] == '0)
        begin
            // A zero first word marks the head slot as empty.
            deq_empty++;
        end
        else
        begin
            reply.ok = 1'b1;
            reply.d0 = mdl_slots[mdl_rd_ptr[PTR_W-2:0]][0];
            reply.d1 = mdl_slots[mdl_rd_ptr[PTR_W-2:0]][1];
            reply.d2 = mdl_slots[mdl_rd_ptr[PTR_W-2:0]][2];
            reply.d3 = mdl_slots[mdl_rd_ptr[PTR_W-2:0]][3];
            mdl_slots[mdl_rd_ptr[PTR_W-2:0]][0] = '0;
            mdl_rd_ptr = mdl_rd_ptr + 1'b1;
            deq_taken++;
        end
        return reply;
    endfunction

    // Reports one reply field that differs from the prediction.
    function automatic void check_field(string name, logic [IO_WORD_W-1:0] want,
                                        logic [IO_WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Message word with extra weight on all zeros and all ones.
    function automatic logic [IO_WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(input logic op_kind, input logic [IO_WORD_W-1:0] w0,
                           input logic [IO_WORD_W-1:0] w1, input logic [IO_WORD_W-1:0] w2,
                           input logic [IO_WORD_W-1:0] w3);
        ops_to_send.push_back(queue_op_t'{op_kind, w0, w1, w2, w3});
    endtask

    // Runs of enqueues or dequeues fill the queue to full and drain it to
    // empty; a few stray operations of the other kind are mixed in.
    task automatic queue_random_ops(input int count, input int enq_pct);
        logic run_kind;
        int   run_len;
        logic op_kind;
        while (count > 0)
        begin
            run_kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
            run_len  = $urandom_range(1, 20);
            for (int i = 0; i < run_len && count > 0; i++)
            begin
                op_kind = ($urandom_range(0, 9) == 0) ? ~run_kind : run_kind;
                push_op(op_kind, pick_word(), pick_word(), pick_word(), pick_word());
                count--;
            end
        end
    endtask

    // Register write; the model takes the new value at once since the queue is idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_BATCH_ENABLE)
            mdl_batch_en = val[0];
        else if (idx == REG_BATCH_SIZE)
            mdl_batch_size = val[BATCH_SIZE_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Waits until every queued operation is sent and every predicted reply has come back.
    task automatic drain();
        do
            @(negedge clk);
        while (ops_to_send.size() != 0 || in_valid || predicted_replies.size() != 0);
    endtask

    task automatic run_phase(input int count, input int enq_pct, input logic long_hold);
        @(negedge clk);
        settings_used++;
        if (long_hold)
            hold_requests++;
        queue_random_ops(count, enq_pct);
        drain();
    endtask

    // Driver: offers queued operations and records a prediction per accepted beat.
    always @(posedge clk)
    begin : sender
        queue_op_t next_op;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predicted_replies.push_back(apply_queue_op(queue_op_t'{kind,
                    first_word, second_word, third_word, fourth_word}));
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (ops_to_send.size() != 0)
                begin
                    next_op = ops_to_send.pop_front();
                    in_valid    <= 1'b1;
                    kind        <= next_op.kind;
                    first_word  <= next_op.w0;
                    second_word <= next_op.w1;
                    third_word  <= next_op.w2;
                    fourth_word <= next_op.w3;
                    if (!quiet_tail && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 13);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each reply beat and paces out_ready.
    always @(posedge clk)
    begin : receiver
        queue_reply_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $error("Reply beat arrived with no prediction waiting");
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    check_field("accepted", IO_WORD_W'(want.ok), IO_WORD_W'(accepted));
                    check_field("out_first", want.d0, out_first);
                    check_field("out_second", want.d1, out_second);
                    check_field("out_third", want.d2, out_third);
                    check_field("out_fourth", want.d3, out_fourth);
                end
            end

            // A long hold keeps a result waiting in the core and so stalls its input side.
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (holds_done != hold_requests)
            begin
                holds_done <= holds_done + 1;
                hold_left  <= LONG_HOLD - 1;
                out_ready  <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 12);
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("slot_marker_ring_queue_core_test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        for (int s = 0; s < SLOTS; s++)
            for (int w = 0; w < IO_WORDS; w++)
                mdl_slots[s][w] = '0;
        mdl_rd_ptr     = '0;
        mdl_wr_ptr     = '0;
        mdl_mark       = '0;
        mdl_batch_en   = 1'b0;
        mdl_batch_size = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: dequeue from empty, extreme words, a zero first word that
        // reads as empty at the head, wrap-around and a refusal when full.
        @(negedge clk);
        settings_used++;
        push_op(KIND_DEQ, '0, '0, '0, '0);
        push_op(KIND_ENQ, '1, '1, '1, '1);
        push_op(KIND_ENQ, '0, 32'h1234_5678, 32'h9abc_def0, '1);
        push_op(KIND_ENQ, 32'h0000_0001, '0, '0, '0);
        push_op(KIND_DEQ, '1, '1, '1, '1);
        push_op(KIND_DEQ, '0, '0, '0, '0);
        push_op(KIND_ENQ, 32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001);
        for (int i = 0; i < 15; i++)
            push_op(KIND_ENQ, 32'h0000_0100 + i, 32'hffff_0000 - i, $urandom, $urandom);
        push_op(KIND_DEQ, '0, '0, '0, '0);
        push_op(KIND_DEQ, '0, '0, '0, '0);
        drain();

        // Plain mode at reset settings.
        run_phase(140, 55, 1'b0);

        // Batch reservation one slot ahead, with a long reply hold.
        write_reg(REG_BATCH_ENABLE, 4'h1);
        write_reg(REG_BATCH_SIZE, 4'h0);
        run_phase(130, 60, 1'b1);

        // Largest batch probe.
        write_reg(REG_BATCH_SIZE, 4'hf);
        run_phase(130, 65, 1'b0);

        // Batching off again; the reserve mark keeps its value meanwhile.
        write_reg(REG_BATCH_ENABLE, 4'he);
        write_reg(REG_BATCH_SIZE, 4'h7);
        run_phase(130, 50, 1'b0);

        // Batching back on through the upper data bits; spare indexes ignored.
        write_reg(REG_BATCH_ENABLE, 4'hf);
        write_reg(REG_BATCH_SIZE, 4'($urandom_range(1, 14)));
        write_reg(REG_SPARE_A, 4'h0);
        write_reg(REG_SPARE_B, 4'h1);
        run_phase(130, 55, 1'b0);

        // Final stretch at full rate with no idling.
        write_reg(REG_BATCH_SIZE, 4'($urandom_range(0, 15)));
        @(negedge clk);
        quiet_tail = 1'b1;
        run_phase(120, 55, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d queue operations under %0d register settings: %0d enqueues stored, %0d refused as full.",
                 enq_stored + enq_full + deq_taken + deq_empty, settings_used,
                 enq_stored, enq_full);
        $display("%0d dequeues returned a message, %0d met an empty head slot; %0d mismatches.",
                 deq_taken, deq_empty, mismatch_count);
        if (mismatch_count == 0 && predicted_replies.size() == 0)
            $display("slot_marker_ring_queue_core_test passed");
        else
            $display("slot_marker_ring_queue_core_test failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/smrq_pkg.sv
design/smrq_ctrl.sv
design/smrq_dp.sv
design/slot_marker_ring_queue_core.sv
verif/slot_marker_ring_queue_core_test.sv
